// ----- rtl/gamepad_input_edge_hysteresis_top_macros.svh -----
// assertion macros used by the gamepad conditioner checker
// each macro expands to one concurrent assertion clocked on clk, held off while arst_n is low
`ifndef GAMEPAD_INPUT_EDGE_HYSTERESIS_TOP_MACROS_SVH
`define GAMEPAD_INPUT_EDGE_HYSTERESIS_TOP_MACROS_SVH

// same-cycle implication
`define GPAD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPAD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gpad_pkg.sv -----
// types, beat layouts and constants of the gamepad input conditioner
// no dependencies; used by the top level, its checker and the testbench
`timescale 1ns / 1ps

package gpad_pkg;

	localparam int BTN_W     = 15;
	localparam int AXIS_W    = 16;
	localparam int SLOT_W    = 3;
	localparam int DIR_W     = 8;
	localparam int FPB_W     = 5;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int MAG_W     = 32;

	localparam int IN_TDATA_W  = 88;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 80;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 2'd2;

	localparam logic [CFG_W-1:0] DEADZONE_RST = 16'd4915;
	localparam logic [CFG_W-1:0] PRESS_RST    = 16'd16384;
	localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd13107;

	localparam logic signed [FPB_W-1:0] FPB_NONE = -5'sd1;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_ATTACH = 2'd1,
		FUNC_DETACH = 2'd2,
		FUNC_RSVD   = 2'd3
	} func_t;

	typedef struct packed {
		logic [5:0]               rsvd;
		logic signed [AXIS_W-1:0] right_y;
		logic signed [AXIS_W-1:0] right_x;
		logic signed [AXIS_W-1:0] left_y;
		logic signed [AXIS_W-1:0] left_x;
		logic [BTN_W-1:0]         buttons;
		logic [SLOT_W-1:0]        slot;
	} in_data_t;

	typedef struct packed {
		logic                    new_frame;
		logic [1:0]              func;
	} in_user_t;

	typedef struct packed {
		logic [4:0]              rsvd;
		logic signed [FPB_W-1:0] first_pressed_button;
		logic [DIR_W-1:0]        dir_released;
		logic [DIR_W-1:0]        dir_pressed;
		logic [DIR_W-1:0]        dir_down;
		logic [BTN_W-1:0]        buttons_released;
		logic [BTN_W-1:0]        buttons_pressed;
		logic [BTN_W-1:0]        buttons_down;
		logic                    connected;
	} out_data_t;

	// threshold times 32767, the common scale of all magnitude compares
	function automatic logic [MAG_W-1:0] scale_thr(input logic [CFG_W-1:0] t);
		return {1'b0, t, 15'b0} - {16'b0, t};
	endfunction

	// raw axis magnitude on the same scale: 32768 per step above zero, 32767 below
	function automatic logic [MAG_W-1:0] scale_axis(input logic [AXIS_W-1:0] raw);
		logic [16:0] num;
		num = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
		return raw[15] ? ({num, 15'b0} - {15'b0, num}) : {num, 15'b0};
	endfunction

endpackage

// ----- rtl/gamepad_input_edge_hysteresis_top.sv -----
// gamepad input conditioner: slot table, button edges, stick deadzone and hysteresis
// depends on gpad_pkg
`timescale 1ns / 1ps

// usage
//  s_* channel: one beat per item. tuser selects sample, attach or detach and flags
//  the first sample of a frame; tdata carries slot, raw buttons and four stick axes.
//  m_* channel: one beat per item with connect status, button level and edges,
//  stick direction level and edges, and the frame's first newly pressed button.
//  cfg_*: deadzone, press and release thresholds (Q1.15), written while idle.
// timing
//  an accepted beat lands in the input register; its result then moves into the output
//  register. one beat per cycle is sustained while m_tready stays high: slot state is
//  read and written back in the same cycle, so back-to-back beats to one slot
//  see each other's updates.
// reset
//  all slots free and cleared, frame report at none, thresholds at defaults.
// stalls
//  with m_tready low the result holds in the output register while one more beat
//  is taken into the input register; s_tready then drops until the result moves.
module gamepad_input_edge_hysteresis_top #(
	parameter int NUM_PADS    = 8,
	parameter int NUM_BUTTONS = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gpad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gpad_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// slot, buttons, left_x, left_y, right_x, right_y, zero fill
	input  logic [gpad_pkg::IN_TDATA_W-1:0]   s_tdata,
	// func, new_frame
	input  logic [gpad_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// connected, buttons_down, buttons_pressed, buttons_released, dir_down,
	// dir_pressed, dir_released, first_pressed_button, zero fill
	output logic [gpad_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import gpad_pkg::*;

	localparam int BtnW = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

	logic [CFG_W-1:0] deadzone_q, press_q, release_q;

	in_data_t in_s1;
	func_t    func_s1;
	logic     new_frame_s1;
	logic     vld_s1;

	logic                    conn_q [NUM_PADS];
	logic [BtnW-1:0]         btn_q  [NUM_PADS];
	logic [DIR_W-1:0]        dir_q  [NUM_PADS];
	logic signed [FPB_W-1:0] fpb_q;

	out_data_t out_q;
	logic      out_vld_q;

	logic                    advance;
	logic                    hit, conn_rd, act, conn_after;
	logic [BtnW-1:0]         btn_rd, btn_new;
	logic [DIR_W-1:0]        dir_rd, dir_new;
	logic [BTN_W-1:0]        bp, br, bd;
	logic [DIR_W-1:0]        sp, sr, sd;
	logic [MAG_W-1:0]        dz_s, pth_s, rth_s;
	logic [CFG_W-1:0]        rel_eff;
	logic [MAG_W-1:0]        axis_mag [4];
	logic [MAG_W-1:0]        mag [DIR_W];
	logic signed [FPB_W-1:0] fpb_base, fpb_next, low_bit;
	in_user_t                user_in;
	out_data_t               res;

	assign user_in  = in_user_t'(s_tuser);
	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// slot read
	always_comb begin
		hit     = 1'b0;
		conn_rd = 1'b0;
		btn_rd  = '0;
		dir_rd  = '0;
		for (int i = 0; i < NUM_PADS; i++) begin
			if (int'(in_s1.slot) == i) begin
				hit     = 1'b1;
				conn_rd = conn_q[i];
				btn_rd  = btn_q[i];
				dir_rd  = dir_q[i];
			end
		end
	end

	assign act     = (func_s1 == FUNC_SAMPLE) && hit && conn_rd;
	assign btn_new = in_s1.buttons[BtnW-1:0];

	assign bd = act ? BTN_W'(btn_new) : '0;
	assign bp = act ? BTN_W'(btn_new & ~btn_rd) : '0;
	assign br = act ? BTN_W'(~btn_new & btn_rd) : '0;

	// stick directions
	assign rel_eff = (release_q < press_q) ? release_q : press_q;
	assign dz_s    = scale_thr(deadzone_q);
	assign pth_s   = scale_thr(press_q);
	assign rth_s   = scale_thr(rel_eff);

	always_comb begin
		axis_mag[0] = scale_axis(in_s1.left_x);
		axis_mag[1] = scale_axis(in_s1.left_y);
		axis_mag[2] = scale_axis(in_s1.right_x);
		axis_mag[3] = scale_axis(in_s1.right_y);
	end

	always_comb begin
		logic [AXIS_W-1:0] raw;
		logic              live;
		for (int a = 0; a < 4; a++) begin
			unique case (a)
				0: raw = in_s1.left_x;
				1: raw = in_s1.left_y;
				2: raw = in_s1.right_x;
				default: raw = in_s1.right_y;
			endcase
			live = axis_mag[a] > dz_s;
			// even bit takes the negative side, odd bit the positive side
			mag[2*a]   = (live && raw[15])  ? axis_mag[a] : '0;
			mag[2*a+1] = (live && !raw[15]) ? axis_mag[a] : '0;
		end
	end

	always_comb begin
		for (int d = 0; d < DIR_W; d++) begin
			dir_new[d] = dir_rd[d] ? (mag[d] > rth_s) : (mag[d] >= pth_s);
		end
	end

	assign sd = act ? dir_new : '0;
	assign sp = act ? (dir_new & ~dir_rd) : '0;
	assign sr = act ? (dir_rd & ~dir_new) : '0;

	// lowest newly pressed button
	always_comb begin
		low_bit = FPB_NONE;
		for (int i = BTN_W - 1; i >= 0; i--) begin
			if (bp[i]) begin
				low_bit = FPB_W'(i);
			end
		end
	end

	assign fpb_base = ((func_s1 == FUNC_SAMPLE) && new_frame_s1) ? FPB_NONE : fpb_q;
	assign fpb_next = (fpb_base[FPB_W-1] && (bp != '0)) ? low_bit : fpb_base;

	always_comb begin
		unique case (func_s1)
			FUNC_ATTACH: conn_after = hit;
			FUNC_DETACH: conn_after = 1'b0;
			default:     conn_after = hit && conn_rd;
		endcase
	end

	always_comb begin
		res                      = '0;
		res.connected            = conn_after;
		res.buttons_down         = bd;
		res.buttons_pressed      = bp;
		res.buttons_released     = br;
		res.dir_down             = sd;
		res.dir_pressed          = sp;
		res.dir_released         = sr;
		res.first_pressed_button = fpb_next;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= DEADZONE_RST;
			press_q    <= PRESS_RST;
			release_q  <= RELEASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEADZONE: deadzone_q <= cfg_wdata;
				REG_PRESS:    press_q    <= cfg_wdata;
				REG_RELEASE:  release_q  <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1        <= in_data_t'(s_tdata);
			func_s1      <= func_t'(user_in.func);
			new_frame_s1 <= user_in.new_frame;
		end
	end

	// slot table and frame report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PADS; i++) begin
				conn_q[i] <= 1'b0;
				btn_q[i]  <= '0;
				dir_q[i]  <= '0;
			end
			fpb_q <= FPB_NONE;
		end else if (advance) begin
			fpb_q <= fpb_next;
			for (int i = 0; i < NUM_PADS; i++) begin
				if (int'(in_s1.slot) == i) begin
					unique case (func_s1)
						FUNC_SAMPLE: begin
							if (conn_q[i]) begin
								btn_q[i] <= btn_new;
								dir_q[i] <= dir_new;
							end
						end
						FUNC_ATTACH: begin
							if (!conn_q[i]) begin
								conn_q[i] <= 1'b1;
								btn_q[i]  <= '0;
								dir_q[i]  <= '0;
							end
						end
						FUNC_DETACH: begin
							conn_q[i] <= 1'b0;
							btn_q[i]  <= '0;
							dir_q[i]  <= '0;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

endmodule

// ----- rtl/gpad_checker.sv -----
// port-level checks of the gamepad input conditioner, bound to the top level
// depends on gpad_pkg and gamepad_input_edge_hysteresis_top_macros.svh
`timescale 1ns / 1ps
`include "gamepad_input_edge_hysteresis_top_macros.svh"

module gpad_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [gpad_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import gpad_pkg::*;

	out_data_t ov;
	logic      btn_ok, stk_ok, quiet_ok, fpb_ok;

	assign ov = out_data_t'(m_tdata);

	// an edge needs the matching level, and a button cannot both press and release
	assign btn_ok = ((ov.buttons_pressed & ov.buttons_released) == '0)
		&& ((ov.buttons_pressed & ~ov.buttons_down) == '0)
		&& ((ov.buttons_released & ov.buttons_down) == '0);

	assign stk_ok = ((ov.dir_pressed & ~ov.dir_down) == '0)
		&& ((ov.dir_released & ov.dir_down) == '0);

	// a slot that is not connected reports no button level, no button press and no stick activity
	assign quiet_ok = (ov.buttons_down == '0) && (ov.buttons_pressed == '0)
		&& (ov.dir_down == '0) && (ov.dir_pressed == '0) && (ov.dir_released == '0);

	// report is none or a button index below the button count
	assign fpb_ok = (ov.first_pressed_button == FPB_NONE)
		|| (!ov.first_pressed_button[FPB_W-1] && (ov.first_pressed_button != 5'sd15));

	// a held result beat keeps its contents
	`GPAD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	`GPAD_ASSERT_NOW(a_btn_edges, m_tvalid, btn_ok, "inconsistent button edges")

	`GPAD_ASSERT_NOW(a_stick_edges, m_tvalid, stk_ok, "inconsistent stick edges")

	`GPAD_ASSERT_NOW(a_free_quiet, m_tvalid && !ov.connected, quiet_ok, "activity on a free slot")

	`GPAD_ASSERT_NOW(a_fpb_range, m_tvalid, fpb_ok, "first pressed button out of range")

endmodule

bind gamepad_input_edge_hysteresis_top gpad_checker u_gpad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- sim/tb_gamepad_input_edge_hysteresis_top.sv -----
// testbench for the gamepad input conditioner: drives sample, attach, detach and reserved beats
// and checks each result beat against an in-bench model of slots, edges and hysteresis
// depends on gpad_pkg and gamepad_input_edge_hysteresis_top
`timescale 1ns / 1ps

module tb_gamepad_input_edge_hysteresis_top;

	import gpad_pkg::*;

	localparam int PADS = 8;
	localparam int PHASES = 7;
	localparam int PHASE_BEATS = 193;

	typedef struct packed {
		in_user_t u;
		in_data_t d;
	} pad_beat_t;

	// conditioner model plus the queue of results it still owes
	class pad_scoreboard;
		logic [CFG_W-1:0]        deadzone;
		logic [CFG_W-1:0]        press_thr;
		logic [CFG_W-1:0]        release_thr;
		logic                    slot_on [PADS];
		logic [BTN_W-1:0]        btn_level [PADS];
		logic [DIR_W-1:0]        dir_level [PADS];
		logic signed [FPB_W-1:0] frame_first;
		out_data_t               owed_results [$];
		int                      mismatches;
		int                      beats_seen;
		int                      results_seen;
		int                      attaches;
		int                      frame_starts;
		int                      stick_presses;

		function new();
			deadzone = DEADZONE_RST;
			press_thr = PRESS_RST;
			release_thr = RELEASE_RST;
			for (int i = 0; i < PADS; i++) begin
				slot_on[i] = 1'b0;
				btn_level[i] = '0;
				dir_level[i] = '0;
			end
			frame_first = FPB_NONE;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == REG_DEADZONE)
				deadzone = v;
			else if (idx == REG_PRESS)
				press_thr = v;
			else if (idx == REG_RELEASE)
				release_thr = v;
		endfunction

		// magnitude on the common scale 32767*32768
		function longint axis_mag(logic signed [AXIS_W-1:0] v);
			if (v < 0)
				return -longint'(v) * 32767;
			return longint'(v) * 32768;
		endfunction

		function out_data_t condition_item(in_user_t u, in_data_t d);
			out_data_t               r;
			logic signed [AXIS_W-1:0] axes [4];
			longint                  mags [8];
			longint                  m;
			longint                  pth;
			longint                  rth;
			logic [CFG_W-1:0]        rel;
			logic [BTN_W-1:0]        prev;
			logic [DIR_W-1:0]        was;
			logic [DIR_W-1:0]        now;
			int                      s;
			r = '0;
			s = int'(d.slot);
			if (u.func == FUNC_ATTACH) begin
				if (s < PADS && !slot_on[s]) begin
					slot_on[s] = 1'b1;
					btn_level[s] = '0;
					dir_level[s] = '0;
					attaches++;
				end
			end else if (u.func == FUNC_DETACH) begin
				if (s < PADS) begin
					slot_on[s] = 1'b0;
					btn_level[s] = '0;
					dir_level[s] = '0;
				end
			end else if (u.func == FUNC_SAMPLE) begin
				if (u.new_frame) begin
					frame_first = FPB_NONE;
					frame_starts++;
				end
				if (s < PADS && slot_on[s]) begin
					prev = btn_level[s];
					r.buttons_down = d.buttons;
					r.buttons_pressed = d.buttons & ~prev;
					r.buttons_released = ~d.buttons & prev;
					if (frame_first < 0 && r.buttons_pressed != 0) begin
						for (int b = BTN_W - 1; b >= 0; b--)
							if (r.buttons_pressed[b])
								frame_first = FPB_W'(b);
					end
					btn_level[s] = d.buttons;

					axes[0] = d.left_x;
					axes[1] = d.left_y;
					axes[2] = d.right_x;
					axes[3] = d.right_y;
					for (int a = 0; a < 4; a++) begin
						m = axis_mag(axes[a]);
						mags[2*a] = 0;
						mags[2*a+1] = 0;
						if (m > longint'(deadzone) * 32767) begin
							if (axes[a] < 0)
								mags[2*a] = m;
							else
								mags[2*a+1] = m;
						end
					end
					rel = (release_thr < press_thr) ? release_thr : press_thr;
					pth = longint'(press_thr) * 32767;
					rth = longint'(rel) * 32767;
					was = dir_level[s];
					now = '0;
					for (int k = 0; k < DIR_W; k++) begin
						if (!was[k])
							now[k] = (mags[k] >= pth);
						else
							now[k] = (mags[k] > rth);
					end
					r.dir_down = now;
					r.dir_pressed = now & ~was;
					r.dir_released = was & ~now;
					stick_presses += $countones(r.dir_pressed);
					dir_level[s] = now;
				end
			end
			r.connected = (s < PADS) && slot_on[s];
			r.first_pressed_button = frame_first;
			return r;
		endfunction

		function void note_beat(in_user_t u, in_data_t d);
			owed_results.push_back(condition_item(u, d));
			beats_seen++;
		endfunction

		task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
			if (mismatches < 40)
				$display("[%0t] mismatch on result %0d, %s: expected %0h got %0h",
					$realtime, results_seen, what, want, got);
			mismatches++;
		endtask

		task check_beat(out_data_t got);
			out_data_t want;
			results_seen++;
			if (owed_results.size() == 0) begin
				report_mismatch("unexpected result beat", 0, got.connected);
				return;
			end
			want = owed_results.pop_front();
			if (want.connected !== got.connected)
				report_mismatch("connected", want.connected, got.connected);
			if (want.buttons_down !== got.buttons_down)
				report_mismatch("buttons_down", want.buttons_down, got.buttons_down);
			if (want.buttons_pressed !== got.buttons_pressed)
				report_mismatch("buttons_pressed", want.buttons_pressed, got.buttons_pressed);
			if (want.buttons_released !== got.buttons_released)
				report_mismatch("buttons_released", want.buttons_released,
					got.buttons_released);
			if (want.dir_down !== got.dir_down)
				report_mismatch("dir_down", want.dir_down, got.dir_down);
			if (want.dir_pressed !== got.dir_pressed)
				report_mismatch("dir_pressed", want.dir_pressed, got.dir_pressed);
			if (want.dir_released !== got.dir_released)
				report_mismatch("dir_released", want.dir_released, got.dir_released);
			if (want.first_pressed_button !== got.first_pressed_button)
				report_mismatch("first_pressed_button", want.first_pressed_button,
					got.first_pressed_button);
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	pad_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	logic [BTN_W-1:0] last_buttons [PADS];

	// threshold settings and idling mode per random phase
	int phase_dz [PHASES]   = '{4915, 0, 32768, 1000, 65535, 0, 2500};
	int phase_pr [PHASES]   = '{16384, 32768, 0, 20000, 40000, 0, 12000};
	int phase_rl [PHASES]   = '{13107, 0, 65535, 5000, 32768, 0, 11999};
	int phase_send [PHASES] = '{0, 47, 0, 7, 0, 47, 0};
	int phase_recv [PHASES] = '{0, 0, 47, 7, 0, 0, 47};
	int phase_hold [PHASES] = '{0, 0, 0, 0, 300, 0, 0};

	gamepad_input_edge_hysteresis_top #(
		.NUM_PADS(PADS),
		.NUM_BUTTONS(BTN_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(out_data_t'(m_tdata));
	end

	function automatic pad_beat_t mk(func_t f, logic [SLOT_W-1:0] slot, logic nf,
		logic [BTN_W-1:0] btn, logic signed [AXIS_W-1:0] lx, ly, rx, ry);
		pad_beat_t b;
		b = '0;
		b.u.func = f;
		b.u.new_frame = nf;
		b.d.slot = slot;
		b.d.buttons = btn;
		b.d.left_x = lx;
		b.d.left_y = ly;
		b.d.right_x = rx;
		b.d.right_y = ry;
		return b;
	endfunction

	task automatic send_beat(pad_beat_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b.d;
		s_tuser <= b.u;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_beat(b.u, b.d);
	endtask

	task automatic set_thresholds(logic [CFG_W-1:0] dz, logic [CFG_W-1:0] pr,
		logic [CFG_W-1:0] rl);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEADZONE;
		cfg_wdata <= dz;
		@(posedge clk);
		cfg_index <= REG_PRESS;
		cfg_wdata <= pr;
		@(posedge clk);
		cfg_index <= REG_RELEASE;
		cfg_wdata <= rl;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_DEADZONE, dz);
		sb.set_reg(REG_PRESS, pr);
		sb.set_reg(REG_RELEASE, rl);
	endtask

	task automatic wait_drained();
		while (sb.owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// axis values clustered around the current thresholds, where hysteresis matters
	function automatic logic signed [AXIS_W-1:0] pick_axis();
		int v;
		case ($urandom_range(0, 9))
			0, 1: v = $signed(16'($urandom));
			2, 3: v = int'(sb.press_thr) + $urandom_range(0, 4) - 2;
			4, 5: v = int'(sb.release_thr) + $urandom_range(0, 4) - 2;
			6: v = int'(sb.deadzone) + $urandom_range(0, 4) - 2;
			7: v = 0;
			8: v = $urandom_range(0, 1) ? 32767 : -32768;
			default: v = $urandom_range(0, 20000);
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return AXIS_W'(v);
	endfunction

	function automatic logic [BTN_W-1:0] pick_buttons(int slot);
		logic [BTN_W-1:0] b;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: b = BTN_W'($urandom);
			4, 5, 6: b = last_buttons[slot] ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
			7: b = last_buttons[slot] ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1))
				^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
			8: b = last_buttons[slot];
			default: b = $urandom_range(0, 1) ? '1 : '0;
		endcase
		return b;
	endfunction

	task automatic run_random(int n);
		pad_beat_t b;
		func_t     f;
		int        slot;
		int        r;
		// connect a few pads first so most samples land on live slots
		repeat (3)
			send_beat(mk(FUNC_ATTACH, SLOT_W'($urandom_range(0, PADS - 1)), 1'b0, '0,
				0, 0, 0, 0));
		repeat (n - 3) begin
			r = $urandom_range(0, 99);
			f = (r < 82) ? FUNC_SAMPLE : (r < 90) ? FUNC_ATTACH :
				(r < 97) ? FUNC_DETACH : FUNC_RSVD;
			slot = $urandom_range(0, PADS - 1);
			b = mk(f, SLOT_W'(slot), ($urandom_range(0, 9) == 0), pick_buttons(slot),
				pick_axis(), pick_axis(), pick_axis(), pick_axis());
			if (f == FUNC_SAMPLE)
				last_buttons[slot] = b.d.buttons;
			send_beat(b);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic run_directed();
		// free slot sample, reserved code, detach of a free slot
		send_beat(mk(FUNC_SAMPLE, 0, 1'b1, 15'h7fff, 100, 100, 100, 100));
		send_beat(mk(FUNC_RSVD, 0, 1'b0, 15'h7fff, 0, 0, 0, 0));
		send_beat(mk(FUNC_DETACH, 1, 1'b0, 0, 0, 0, 0, 0));
		// attach, then attach again which keeps the history
		send_beat(mk(FUNC_ATTACH, 0, 1'b0, 0, 0, 0, 0, 0));
		send_beat(mk(FUNC_SAMPLE, 0, 1'b1, 15'h7fff, -32768, 32767, 16384, -16384));
		send_beat(mk(FUNC_ATTACH, 0, 1'b0, 0, 0, 0, 0, 0));
		// release boundaries: exact release level drops, one step above holds
		send_beat(mk(FUNC_SAMPLE, 0, 1'b0, 15'h0000, -13107, 13108, 16383, 0));
		send_beat(mk(FUNC_SAMPLE, 0, 1'b0, 15'h0001, 16383, -16383, 32767, -32768));
		send_beat(mk(FUNC_ATTACH, 3, 1'b0, 0, 0, 0, 0, 0));
		send_beat(mk(FUNC_SAMPLE, 3, 1'b0, 15'h4000, 0, 0, 0, 0));
		send_beat(mk(FUNC_SAMPLE, 0, 1'b1, 15'h0000, 0, 0, 0, 0));
		send_beat(mk(FUNC_SAMPLE, 3, 1'b0, 15'h4008, 4915, -4915, 4916, -4916));
		send_beat(mk(FUNC_RSVD, 3, 1'b1, 15'h7fff, 0, 0, 0, 0));
		send_beat(mk(FUNC_SAMPLE, 5, 1'b1, 15'h7fff, 32767, 32767, 32767, 32767));
		send_beat(mk(FUNC_SAMPLE, 3, 1'b0, 15'h0000, 32767, -32768, -32768, 32767));
		send_beat(mk(FUNC_DETACH, 0, 1'b0, 0, 0, 0, 0, 0));
		send_beat(mk(FUNC_SAMPLE, 0, 1'b0, 15'h2aaa, -32768, -32768, -32768, -32768));
		send_beat(mk(FUNC_SAMPLE, 3, 1'b1, 15'h5555, 0, 0, 0, 0));
		s_tvalid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		for (int i = 0; i < PADS; i++)
			last_buttons[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			set_thresholds(CFG_W'(phase_dz[p]), CFG_W'(phase_pr[p]), CFG_W'(phase_rl[p]));
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_recv[p];
			// long receiver hold-off while the sender keeps offering beats
			if (phase_hold[p] > 0)
				hold_req = phase_hold[p];
			run_random(PHASE_BEATS);
			wait_drained();
		end
		repeat (10) @(posedge clk);

		if (sb.owed_results.size() != 0)
			sb.report_mismatch("results never delivered", 0, sb.owed_results.size());
		$display("%0d beats in, %0d results checked, %0d threshold settings",
			sb.beats_seen, sb.results_seen, PHASES + 1);
		$display("%0d slot attaches, %0d frame starts, %0d stick press edges",
			sb.attaches, sb.frame_starts, sb.stick_presses);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
